// File: rtl/core/qbrc_pkg.sv
// Shared types and constants for the quiz buzzer round controller.
// No dependencies; imported by qbrc_button and quiz_buzzer_round_controller.
package qbrc_pkg;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_ARMED  = 2'd1,
		PH_LOCKED = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_ARM     = 3'd1,
		EV_DISARM  = 3'd2,
		EV_RESET   = 3'd3,
		EV_ACK     = 3'd4,
		EV_LOCKOUT = 3'd5,
		EV_HOST    = 3'd6
	} event_kind_t;

	typedef enum logic [1:0] {
		PRESS_NONE  = 2'd0,
		PRESS_SHORT = 2'd1,
		PRESS_LONG  = 2'd2
	} press_t;

	// configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_HALF = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_HOST_BTN   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_PLAYERS    = 3'd4;

	// reset values of the configuration registers
	localparam logic [7:0]  DEBOUNCE_DEF   = 8'd30;
	localparam logic [15:0] LONG_PRESS_DEF = 16'd800;
	localparam logic [15:0] BLINK_HALF_DEF = 16'd200;
	localparam logic        HOST_BTN_DEF   = 1'b1;
	localparam logic [4:0]  PLAYERS_DEF    = 5'd8;

	localparam int MAX_PLAYERS_DEF = 16;
	localparam int ORDER_DEPTH_DEF = 16;

	localparam int MAX_RESULTS    = 3;
	localparam int RES_FIFO_DEPTH = 4;

	typedef struct packed {
		logic [7:0]  debounce_ticks;
		logic [15:0] long_press_ticks;
	} button_cfg_t;

	typedef struct packed {
		event_kind_t kind;
		logic [7:0]  player;
		logic [15:0] value;
		logic        led;
		logic        last;
	} result_t;

endpackage

// File: rtl/core/qbrc_button.sv
// Debounce and short/long press classification for one button.
// Depends on qbrc_pkg (button_cfg_t, press_t).
module qbrc_button import qbrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick,
	input  logic        level,
	input  button_cfg_t cfg,
	output press_t      press
);

	logic        last_q, stable_q, pressed_q, long_q;
	logic [7:0]  quiet_q;
	logic [15:0] held_q;

	logic        stable_d, pressed_d, long_d;
	logic [7:0]  quiet_d;
	logic [15:0] held_inc, held_d;

	always_comb begin
		held_inc = held_q;
		if (pressed_q && !long_q && held_q != 16'hFFFF) begin
			held_inc = held_q + 16'd1;
		end
		if (level != last_q) begin
			quiet_d = 8'd0;
		end else if (quiet_q != 8'hFF) begin
			quiet_d = quiet_q + 8'd1;
		end else begin
			quiet_d = quiet_q;
		end

		stable_d  = stable_q;
		pressed_d = pressed_q;
		long_d    = long_q;
		held_d    = held_inc;
		press     = PRESS_NONE;

		if (quiet_d >= cfg.debounce_ticks) begin
			if (level && !stable_q) begin
				stable_d  = 1'b1;
				pressed_d = 1'b1;
				long_d    = 1'b0;
				held_d    = 16'd0;
			end else if (level && pressed_q && !long_q) begin
				if (held_inc >= cfg.long_press_ticks) begin
					long_d = 1'b1;
					press  = PRESS_LONG;
				end
			end else if (!level && stable_q) begin
				// long flag survives the release; cleared at the next press
				if (pressed_q && !long_q) begin
					press = PRESS_SHORT;
				end
				stable_d  = 1'b0;
				pressed_d = 1'b0;
			end
		end

		if (!tick) begin
			press = PRESS_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= 1'b0;
			quiet_q   <= 8'd0;
			stable_q  <= 1'b0;
			pressed_q <= 1'b0;
			long_q    <= 1'b0;
			held_q    <= 16'd0;
		end else if (tick) begin
			last_q    <= level;
			quiet_q   <= quiet_d;
			stable_q  <= stable_d;
			pressed_q <= pressed_d;
			long_q    <= long_d;
			held_q    <= held_d;
		end
	end

endmodule

// File: rtl/core/quiz_buzzer_round_controller.sv
// Quiz buzzer round controller: input register, single-pass round logic, result queue.
// An accepted word is held in the input register until the queue has room for its results.
// Throughput: one input word per cycle while each gives one result word and the
// output is not stalled; the four-entry result queue drains one word per cycle
// while out_stall is low. Reset clears all state and loads the configuration defaults;
// no clearing pass is needed.
module quiz_buzzer_round_controller import qbrc_pkg::*; #(
	parameter int MAX_PLAYERS = MAX_PLAYERS_DEF,
	parameter int ORDER_DEPTH = ORDER_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   operation,
	input  logic                   arm_level,
	input  logic                   host_level,
	input  logic [7:0]             buzz_id,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [2:0]             event_kind,
	output logic [7:0]             event_player,
	output logic [15:0]            event_value,
	output logic                   led_on,
	output logic                   last,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CNT_W = $clog2(ORDER_DEPTH + 1);
	localparam int PTR_W = $clog2(RES_FIFO_DEPTH);
	localparam int FCNT_W = $clog2(RES_FIFO_DEPTH + 1);

	// configuration
	logic [7:0]  debounce_q;
	logic [15:0] long_press_q, blink_half_q;
	logic        host_btn_q;
	logic [4:0]  players_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_DEF;
			long_press_q <= LONG_PRESS_DEF;
			blink_half_q <= BLINK_HALF_DEF;
			host_btn_q   <= HOST_BTN_DEF;
			players_q    <= PLAYERS_DEF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEBOUNCE:   debounce_q   <= cfg_data[7:0];
				CFG_LONG_PRESS: long_press_q <= cfg_data;
				CFG_BLINK_HALF: blink_half_q <= cfg_data;
				CFG_HOST_BTN:   host_btn_q   <= cfg_data[0];
				CFG_PLAYERS:    players_q    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// input register
	logic       valid_s1, op_s1, arm_s1, host_s1;
	logic [7:0] pid_s1;
	logic       process, accept;
	logic [FCNT_W-1:0] fcnt_q;

	assign process  = valid_s1 && (fcnt_q <= FCNT_W'(RES_FIFO_DEPTH - MAX_RESULTS));
	assign in_stall = valid_s1 && !process;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= operation;
			arm_s1  <= arm_level;
			host_s1 <= host_level;
			pid_s1  <= buzz_id;
		end
	end

	// buttons
	logic        tick, buzz;
	button_cfg_t btn_cfg;
	press_t      arm_press, host_press;

	assign tick = process && !op_s1;
	assign buzz = process && op_s1;
	assign btn_cfg = '{debounce_ticks: debounce_q, long_press_ticks: long_press_q};

	qbrc_button u_arm_btn (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.level  (arm_s1),
		.cfg    (btn_cfg),
		.press  (arm_press)
	);

	qbrc_button u_host_btn (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.level  (host_s1),
		.cfg    (btn_cfg),
		.press  (host_press)
	);

	// round state
	phase_t                 phase_q, phase_d;
	logic [15:0]            round_q, round_d, round_inc;
	logic [CNT_W-1:0]       buzz_cnt_q, buzz_cnt_d, buzz_inc;
	logic [MAX_PLAYERS-1:0] seen_q, seen_d, id_hot;
	logic [15:0]            blink_cnt_q, blink_cnt_d, half;
	logic [16:0]            blink_inc;
	logic                   blink_q, blink_d;
	logic [7:0]             top_id;
	logic                   id_ok, led;
	result_t                res [MAX_RESULTS];
	logic [1:0]             n_res;

	always_comb begin
		half = (blink_half_q == 16'd0) ? 16'd1 : blink_half_q;
		blink_inc = {1'b0, blink_cnt_q} + 17'd1;
		blink_cnt_d = blink_cnt_q;
		blink_d = blink_q;
		if (tick) begin
			if (blink_inc >= {1'b0, half}) begin
				blink_cnt_d = 16'd0;
				blink_d = ~blink_q;
			end else begin
				blink_cnt_d = blink_inc[15:0];
			end
		end

		round_inc = round_q + 16'd1;
		if (round_inc == 16'd0) begin
			round_inc = 16'd1;
		end
		buzz_inc = buzz_cnt_q + CNT_W'(1);

		for (int i = 0; i < MAX_PLAYERS; i++) begin
			id_hot[i] = (pid_s1 == 8'(i + 1));
		end
		top_id = ({3'b000, players_q} < 8'(MAX_PLAYERS)) ? {3'b000, players_q}
			: 8'(MAX_PLAYERS);
		id_ok = (pid_s1 != 8'd0) && (pid_s1 <= top_id) && ((seen_q & id_hot) == '0)
			&& (buzz_cnt_q < CNT_W'(ORDER_DEPTH));

		phase_d = phase_q;
		round_d = round_q;
		buzz_cnt_d = buzz_cnt_q;
		seen_d = seen_q;
		n_res = 2'd0;
		for (int k = 0; k < MAX_RESULTS; k++) begin
			res[k] = '{kind: EV_NONE, player: 8'd0, value: 16'd0, led: 1'b0, last: 1'b0};
		end

		if (buzz) begin
			if (phase_q != PH_IDLE && id_ok) begin
				seen_d = seen_q | id_hot;
				buzz_cnt_d = buzz_inc;
				res[0] = '{kind: EV_ACK, player: pid_s1, value: 16'(buzz_inc),
					led: 1'b0, last: 1'b0};
				n_res = 2'd1;
				if (buzz_cnt_q == '0) begin
					phase_d = PH_LOCKED;
					res[1] = '{kind: EV_LOCKOUT, player: pid_s1, value: round_q,
						led: 1'b0, last: 1'b0};
					n_res = 2'd2;
				end
			end
		end

		if (tick) begin
			if (arm_press == PRESS_SHORT) begin
				// an active round is reset before the new one is armed
				if (phase_q != PH_IDLE) begin
					res[n_res] = '{kind: EV_RESET, player: 8'd0, value: round_q,
						led: 1'b0, last: 1'b0};
					n_res = n_res + 2'd1;
				end
				round_d = round_inc;
				buzz_cnt_d = '0;
				seen_d = '0;
				phase_d = PH_ARMED;
				res[n_res] = '{kind: EV_ARM, player: 8'd0, value: round_inc,
					led: 1'b0, last: 1'b0};
				n_res = n_res + 2'd1;
			end else if (arm_press == PRESS_LONG) begin
				if (host_btn_q) begin
					phase_d = PH_IDLE;
					res[n_res] = '{kind: EV_DISARM, player: 8'd0, value: round_q,
						led: 1'b0, last: 1'b0};
				end else begin
					res[n_res] = '{kind: EV_HOST, player: 8'd0, value: 16'd0,
						led: 1'b0, last: 1'b0};
				end
				n_res = n_res + 2'd1;
			end
			if (host_press != PRESS_NONE && host_btn_q) begin
				res[n_res] = '{kind: EV_HOST, player: 8'd0, value: 16'd0,
					led: 1'b0, last: 1'b0};
				n_res = n_res + 2'd1;
			end
		end

		if (n_res == 2'd0) begin
			n_res = 2'd1;
		end

		unique case (phase_d)
			PH_ARMED:  led = blink_d;
			PH_LOCKED: led = 1'b1;
			default:   led = 1'b0;
		endcase

		for (int k = 0; k < MAX_RESULTS; k++) begin
			res[k].led  = led;
			res[k].last = (2'(k) == n_res - 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q     <= 16'd0;
			buzz_cnt_q  <= '0;
			seen_q      <= '0;
			blink_cnt_q <= 16'd0;
			blink_q     <= 1'b0;
		end else begin
			round_q     <= round_d;
			buzz_cnt_q  <= buzz_cnt_d;
			seen_q      <= seen_d;
			blink_cnt_q <= blink_cnt_d;
			blink_q     <= blink_d;
		end
	end

	// result queue
	result_t           fifo_q [RES_FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic              pop;
	result_t           head;

	assign out_valid = (fcnt_q != '0);
	assign pop = out_valid && !out_stall;
	assign head = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (process) begin
			for (int k = 0; k < MAX_RESULTS; k++) begin
				if (2'(k) < n_res) begin
					fifo_q[wr_ptr_q + PTR_W'(k)] <= res[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fcnt_q   <= '0;
		end else begin
			if (process) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			fcnt_q <= fcnt_q + (process ? FCNT_W'(n_res) : FCNT_W'(0))
				- (pop ? FCNT_W'(1) : FCNT_W'(0));
		end
	end

	assign event_kind   = head.kind;
	assign event_player = head.player;
	assign event_value  = head.value;
	assign led_on       = head.led;
	assign last         = head.last;

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for quiz_buzzer_round_controller: directed and random runs.
// Needs qbrc_pkg (types, register indexes, defaults) and the controller RTL.
module tb_top;
	import qbrc_pkg::*;

	// Round predictor and expected-event store: each accepted input word is run through a
	// copy of the round logic and its event words are queued for the output side.
	class buzzer_scoreboard;
		logic [7:0]  debounce_ticks;
		logic [15:0] long_press_ticks;
		logic [15:0] blink_half;
		logic        host_btn;
		logic [4:0]  player_count;

		phase_t      phase;
		logic [15:0] round_no;
		int unsigned buzz_count;
		logic [MAX_PLAYERS_DEF-1:0] seen;
		bit          btn_level[2];
		int unsigned btn_quiet[2];
		bit          btn_stable[2];
		bit          btn_pressed[2];
		bit          btn_longfired[2];
		int unsigned btn_held[2];
		int unsigned blink_cnt;
		bit          blink_bit;

		result_t     expected_events[$];
		result_t     word_events[$];
		int unsigned errors;
		int unsigned words_in;
		int unsigned words_out;
		int unsigned kind_seen[8];

		function new();
			debounce_ticks = DEBOUNCE_DEF;
			long_press_ticks = LONG_PRESS_DEF;
			blink_half = BLINK_HALF_DEF;
			host_btn = HOST_BTN_DEF;
			player_count = PLAYERS_DEF;
			phase = PH_IDLE;
			round_no = '0;
			buzz_count = 0;
			seen = '0;
			for (int b = 0; b < 2; b++) begin
				btn_level[b] = 1'b0;
				btn_quiet[b] = 0;
				btn_stable[b] = 1'b0;
				btn_pressed[b] = 1'b0;
				btn_longfired[b] = 1'b0;
				btn_held[b] = 0;
			end
			blink_cnt = 0;
			blink_bit = 1'b0;
			errors = 0;
			words_in = 0;
			words_out = 0;
			foreach (kind_seen[k]) kind_seen[k] = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_DEBOUNCE:   debounce_ticks = data[7:0];
				CFG_LONG_PRESS: long_press_ticks = data[15:0];
				CFG_BLINK_HALF: blink_half = data[15:0];
				CFG_HOST_BTN:   host_btn = data[0];
				CFG_PLAYERS:    player_count = data[4:0];
				default: ;
			endcase
		endfunction

		function void push_event(event_kind_t kind, logic [7:0] player, logic [15:0] value);
			result_t r;
			if (word_events.size() >= MAX_RESULTS)
				return;
			r.kind = kind;
			r.player = player;
			r.value = value;
			r.led = 1'b0;
			r.last = 1'b0;
			word_events.push_back(r);
		endfunction

		function press_t poll_button(int b, bit raw);
			press_t ev;
			ev = PRESS_NONE;
			if (btn_pressed[b] && !btn_longfired[b] && btn_held[b] < 32'hFFFF)
				btn_held[b]++;
			if (raw != btn_level[b]) begin
				btn_level[b] = raw;
				btn_quiet[b] = 0;
			end else if (btn_quiet[b] < 255) begin
				btn_quiet[b]++;
			end
			if (btn_quiet[b] < debounce_ticks)
				return PRESS_NONE;
			if (raw && !btn_stable[b]) begin
				btn_stable[b] = 1'b1;
				btn_pressed[b] = 1'b1;
				btn_longfired[b] = 1'b0;
				btn_held[b] = 0;
			end else if (raw && btn_pressed[b] && !btn_longfired[b]) begin
				if (btn_held[b] >= long_press_ticks) begin
					btn_longfired[b] = 1'b1;
					ev = PRESS_LONG;
				end
			end else if (!raw && btn_stable[b]) begin
				// long flag survives the release; it is cleared by the next press
				if (btn_pressed[b] && !btn_longfired[b])
					ev = PRESS_SHORT;
				btn_stable[b] = 1'b0;
				btn_pressed[b] = 1'b0;
			end
			return ev;
		endfunction

		function void start_round();
			round_no = round_no + 16'd1;
			if (round_no == 16'd0)
				round_no = 16'd1;
			buzz_count = 0;
			seen = '0;
			phase = PH_ARMED;
			push_event(EV_ARM, 8'd0, round_no);
		endfunction

		function void take_buzz(logic [7:0] id);
			int unsigned top;
			top = (player_count < MAX_PLAYERS_DEF) ? player_count : MAX_PLAYERS_DEF;
			if (phase != PH_ARMED && phase != PH_LOCKED)
				return;
			if (id == 8'd0 || id > top)
				return;
			if (seen[id-1])
				return;
			if (buzz_count >= ORDER_DEPTH_DEF)
				return;
			seen[id-1] = 1'b1;
			buzz_count++;
			push_event(EV_ACK, id, 16'(buzz_count));
			if (buzz_count == 1) begin
				phase = PH_LOCKED;
				push_event(EV_LOCKOUT, id, round_no);
			end
		endfunction

		function void take_tick(bit arm, bit host);
			int unsigned half;
			press_t ev;
			half = (blink_half == 16'd0) ? 1 : blink_half;
			blink_cnt++;
			if (blink_cnt >= half) begin
				blink_cnt = 0;
				blink_bit = ~blink_bit;
			end
			ev = poll_button(0, arm);
			if (ev == PRESS_SHORT) begin
				if (phase != PH_IDLE) begin
					buzz_count = 0;
					seen = '0;
					phase = PH_IDLE;
					push_event(EV_RESET, 8'd0, round_no);
				end
				start_round();
			end else if (ev == PRESS_LONG) begin
				if (host_btn) begin
					phase = PH_IDLE;
					push_event(EV_DISARM, 8'd0, round_no);
				end else begin
					push_event(EV_HOST, 8'd0, 16'd0);
				end
			end
			ev = poll_button(1, host);
			if (ev != PRESS_NONE && host_btn)
				push_event(EV_HOST, 8'd0, 16'd0);
		endfunction

		function void predict_word(bit op, bit arm, bit host, logic [7:0] id);
			logic led;
			result_t r;
			word_events.delete();
			if (op)
				take_buzz(id);
			else
				take_tick(arm, host);
			if (word_events.size() == 0)
				push_event(EV_NONE, 8'd0, 16'd0);
			case (phase)
				PH_ARMED:  led = blink_bit;
				PH_LOCKED: led = 1'b1;
				default:   led = 1'b0;
			endcase
			foreach (word_events[k]) begin
				r = word_events[k];
				r.led = led;
				r.last = (k == word_events.size() - 1);
				expected_events.push_back(r);
			end
			words_in++;
		endfunction

		function void check_event(logic [2:0] kind, logic [7:0] player, logic [15:0] value,
				logic led, logic last_flag);
			result_t want;
			if (expected_events.size() == 0) begin
				$error("result word with nothing predicted: event_kind %0d", kind);
				errors++;
				return;
			end
			want = expected_events.pop_front();
			words_out++;
			kind_seen[kind]++;
			if (kind !== want.kind) begin
				$error("event_kind: expected %0d, got %0d", want.kind, kind);
				errors++;
			end
			if (player !== want.player) begin
				$error("event_player: expected %0d, got %0d", want.player, player);
				errors++;
			end
			if (value !== want.value) begin
				$error("event_value: expected %0d, got %0d", want.value, value);
				errors++;
			end
			if (led !== want.led) begin
				$error("led_on: expected %0d, got %0d", want.led, led);
				errors++;
			end
			if (last_flag !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, last_flag);
				errors++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   operation = 1'b0;
	logic                   arm_level = 1'b0;
	logic                   host_level = 1'b0;
	logic [7:0]             buzz_id = 8'd0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [2:0]             event_kind;
	logic [7:0]             event_player;
	logic [15:0]            event_value;
	logic                   led_on;
	logic                   last;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	buzzer_scoreboard sb;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned words_sent = 0;
	int unsigned setups = 0;
	int unsigned cur_db = 0;
	int unsigned cur_long = 0;
	int unsigned cur_pc = 0;

	quiz_buzzer_round_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.arm_level(arm_level),
		.host_level(host_level),
		.buzz_id(buzz_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.event_player(event_player),
		.event_value(event_value),
		.led_on(led_on),
		.last(last),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				sb.predict_word(operation, arm_level, host_level, buzz_id);
			if (out_valid && !out_stall)
				sb.check_event(event_kind, event_player, event_value, led_on, last);
		end
	end

	// output side: random stall, plus a long hold-off when one is requested
	initial begin : receiver
		int unsigned hold_served;
		int unsigned hold_left;
		hold_served = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = 120;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	task automatic send_word(input bit op, input bit arm, input bit host, input logic [7:0] id);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		arm_level <= arm;
		host_level <= host;
		buzz_id <= id;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	// unused fields of a word carry random bits
	task automatic tick(input bit arm, input bit host);
		send_word(1'b0, arm, host, 8'($urandom_range(255)));
	endtask

	task automatic buzz(input logic [7:0] id);
		send_word(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)), id);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic load_setup(input int unsigned db, input int unsigned lp, input int unsigned bh,
			input int unsigned hb, input int unsigned pc);
		write_reg(CFG_DEBOUNCE, 16'(db));
		write_reg(CFG_LONG_PRESS, 16'(lp));
		write_reg(CFG_BLINK_HALF, 16'(bh));
		write_reg(CFG_HOST_BTN, 16'(hb));
		write_reg(CFG_PLAYERS, 16'(pc));
		cfg_we <= 1'b0;
		cur_db = db;
		cur_long = lp;
		cur_pc = pc;
		setups++;
	endtask

	function automatic logic [7:0] pick_player();
		int unsigned top;
		top = (cur_pc == 0) ? 3 : ((cur_pc > 16) ? 17 : cur_pc);
		if ($urandom_range(9) < 8)
			return 8'($urandom_range(top, 1));
		return 8'($urandom_range(255));
	endfunction

	task automatic random_burst();
		int unsigned pick;
		int unsigned n;
		int unsigned hold;
		int unsigned k;
		bit host_side;
		pick = $urandom_range(99);
		if (pick < 50) begin
			// one clean press: settle high, hold a random while, settle low
			host_side = (pick >= 35);
			hold = $urandom_range((cur_long < 12 ? cur_long : 12) + 2);
			for (k = 0; k < cur_db + 1 + hold; k++) begin
				if ($urandom_range(5) == 0)
					buzz(pick_player());
				tick(!host_side, host_side);
			end
			repeat (cur_db + 1) tick(1'b0, 1'b0);
		end else if (pick < 85) begin
			n = $urandom_range(5, 1);
			repeat (n) buzz(pick_player());
		end else begin
			n = $urandom_range(4, 1);
			repeat (n) begin
				if ($urandom_range(1))
					buzz(8'($urandom_range(255)));
				else
					tick(1'($urandom_range(1)), 1'($urandom_range(1)));
			end
		end
	endtask

	task automatic run_random(input int unsigned budget);
		int unsigned stop_at;
		stop_at = words_sent + budget;
		while (words_sent < stop_at)
			random_burst();
	endtask

	initial begin : stimulus
		sb = new();
		tx_idle_pct = 23;
		rx_idle_pct = 78;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		buzz(8'd1);                 // idle, reset defaults
		drain_results();
		load_setup(0, 2, 1, 1, 16);
		tick(1'b1, 1'b0);
		tick(1'b0, 1'b0);           // short press from idle: arm
		buzz(8'd0);
		buzz(8'd17);
		buzz(8'd255);
		buzz(8'd16);                // first buzz: ack and lockout
		buzz(8'd16);                // already seen
		buzz(8'd1);
		tick(1'b1, 1'b0);
		tick(1'b1, 1'b0);
		tick(1'b1, 1'b0);           // long press: disarm
		tick(1'b0, 1'b0);
		buzz(8'd2);                 // idle again
		tick(1'b0, 1'b1);
		tick(1'b0, 1'b0);           // host key
		tick(1'b1, 1'b1);
		tick(1'b0, 1'b0);           // arm and host key together
		tick(1'b1, 1'b1);
		tick(1'b0, 1'b0);           // reset, arm, host key
		buzz(8'd3);
		drain_results();

		load_setup(0, 1, 1, 1, 16);
		run_random(70);
		drain_results();
		load_setup(2, 5, 3, 0, 5);
		run_random(70);
		drain_results();

		tx_idle_pct = 78;
		rx_idle_pct = 23;
		load_setup(1, 0, 0, 1, 31);
		run_random(70);
		drain_results();
		load_setup(3, 8, 65535, 0, 1);
		run_random(60);
		drain_results();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		load_setup(0, 65535, 2, 1, 16);
		hold_requests++;
		run_random(70);
		drain_results();
		load_setup(1, 3, 7, 1, 0);
		run_random(40);
		drain_results();
		repeat (8) @(posedge clk);

		$display("run: %0d input words, %0d result words checked, %0d register setups",
			sb.words_in, sb.words_out, setups);
		$display("events: arm %0d, disarm %0d, reset %0d, ack %0d, lockout %0d, host key %0d",
			sb.kind_seen[EV_ARM], sb.kind_seen[EV_DISARM], sb.kind_seen[EV_RESET],
			sb.kind_seen[EV_ACK], sb.kind_seen[EV_LOCKOUT], sb.kind_seen[EV_HOST]);
		if (sb.errors == 0 && sb.expected_events.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/qbrc_pkg.sv
rtl/core/qbrc_button.sv
rtl/core/quiz_buzzer_round_controller.sv
sim/tb_top.sv
